FILE: src/lwps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwps_pkg
// shared types and constants of the link win-rate primary selector
// ----------------------------------------------------------------------------
package lwps_pkg;

  localparam int unsigned DEF_LINK_SLOTS = 16;
  localparam int unsigned CNT_W          = 32;
  localparam int unsigned LINK_W         = 32;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  typedef enum logic [1:0] {
    CMD_WON   = 2'd0,
    CMD_LOST  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CRD,
    ST_CWR,
    ST_TRD,
    ST_TMUL,
    ST_TCMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [LINK_W-1:0] link_id;
  } req_t;

  typedef struct packed {
    logic [LINK_W-1:0] best_link;
    logic              feedback_sent;
    logic [31:0]       epoch;
    logic              table_full;
  } rsp_t;

  // win and participation counts of one slot
  typedef struct packed {
    logic [CNT_W-1:0] win;
    logic [CNT_W-1:0] part;
  } cnt_t;

  // one link with its counts, as seen by the ratio compare
  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic [CNT_W-1:0]  win;
    logic [CNT_W-1:0]  part;
  } ratio_t;

endpackage

FILE: src/link_win_rate_primary_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_win_rate_primary_select
// per-link race win/participation counters with win-ratio primary pick
// ----------------------------------------------------------------------------
// won/lost request: handled by the link-id scan that reads the slot memory
//   one entry per cycle
// feedback tick: each slot passes a multiply state and a compare state
// clear or ignored request: no scan; one request in flight at a time
// rst (synchronous) frees every slot and zeroes the epoch at once
// ----------------------------------------------------------------------------
module link_win_rate_primary_select #(
  parameter int unsigned LINK_SLOTS = lwps_pkg::DEF_LINK_SLOTS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lwps_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output lwps_pkg::rsp_t rsp
);

  localparam int unsigned IDX_W = (LINK_SLOTS > 1) ? $clog2(LINK_SLOTS) : 1;
  localparam int unsigned ISS_W = $clog2(LINK_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINK_SLOTS - 1);

  // slot memories: link id and counts, one read port with registered data
  logic [lwps_pkg::LINK_W-1:0] link_mem [LINK_SLOTS];
  lwps_pkg::cnt_t              cnt_mem  [LINK_SLOTS];

  lwps_pkg::state_t            state;
  lwps_pkg::state_t            state_next;

  // slot occupancy lives in flip-flops so clear and reset act at once
  logic [LINK_SLOTS-1:0]       used;
  logic [31:0]                 epoch;

  lwps_pkg::cmd_t              cmd_q;
  logic [lwps_pkg::LINK_W-1:0] id_q;

  // memory ports
  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic [lwps_pkg::LINK_W-1:0] link_q;
  lwps_pkg::cnt_t              cnt_q;
  logic                        link_we;
  logic [IDX_W-1:0]            link_wa;
  logic                        cnt_we;
  logic [IDX_W-1:0]            cnt_wa;
  lwps_pkg::cnt_t              cnt_wd;

  // id scan pipeline
  logic [ISS_W-1:0]            iss;
  logic                        iss_more;
  logic                        rd_vld;
  logic [IDX_W-1:0]            rd_idx;
  logic                        free_ok;
  logic [IDX_W-1:0]            free_idx;
  logic                        scan_used;
  logic                        scan_hit;
  logic                        scan_last;
  logic                        alloc_ok;
  logic [IDX_W-1:0]            alloc_idx;
  logic [IDX_W-1:0]            slot;

  // tick sweep
  logic [IDX_W-1:0]            idx;
  logic                        have;
  lwps_pkg::ratio_t            best;
  lwps_pkg::ratio_t            cand_in;
  lwps_pkg::ratio_t            cand_q;
  logic                        cand_ok;
  logic                        ratio_en;
  logic                        better;
  logic                        take;

  lwps_pkg::rsp_t              res_q;

  assign req_stall = (state != lwps_pkg::ST_IDLE);

  // --------------------------------------------------------------------------
  // memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= id_q;
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (rd_en) begin
      link_q <= link_mem[rd_addr];
      cnt_q  <= cnt_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // ratio compare: candidate fresh from memory against the running best
  // --------------------------------------------------------------------------
  assign cand_in = '{link: link_q, win: cnt_q.win, part: cnt_q.part};

  lwps_ratio_cmp u_cmp (
    .clk    (clk),
    .en     (ratio_en),
    .cand   (cand_in),
    .best   (best),
    .better (better)
  );

  // candidate must be in use with nonzero participation; first one always wins
  assign take = cand_ok && (!have || better);

  // --------------------------------------------------------------------------
  // scan decode
  // --------------------------------------------------------------------------
  assign iss_more  = (iss < ISS_W'(LINK_SLOTS));
  assign scan_used = used[rd_idx];
  assign scan_hit  = rd_vld && scan_used && (link_q == id_q);
  assign scan_last = rd_vld && (rd_idx == LAST_IDX);
  // lowest free slot: one found earlier, else the one under the compare now
  assign alloc_ok  = free_ok || !scan_used;
  assign alloc_idx = free_ok ? free_idx : rd_idx;

  // --------------------------------------------------------------------------
  // state register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // next state and memory control
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = idx;
    link_we    = 1'b0;
    link_wa    = alloc_idx;
    cnt_we     = 1'b0;
    cnt_wa     = idx;
    cnt_wd     = '0;
    ratio_en   = 1'b0;
    unique case (state)
      lwps_pkg::ST_IDLE: begin
        if (req_valid) begin
          unique case (req.command) inside
            lwps_pkg::CMD_WON, lwps_pkg::CMD_LOST: begin
              // id zero is unidentified and changes nothing
              state_next = (req.link_id != '0) ? lwps_pkg::ST_SCAN : lwps_pkg::ST_DONE;
            end
            lwps_pkg::CMD_TICK: begin
              // empty table: no pick and no decay
              state_next = (|used) ? lwps_pkg::ST_TRD : lwps_pkg::ST_DONE;
            end
            default: begin
              state_next = lwps_pkg::ST_DONE;
            end
          endcase
        end
      end
      lwps_pkg::ST_SCAN: begin
        // one link-id read issued per cycle, compared the cycle after
        rd_en   = iss_more;
        rd_addr = iss[IDX_W-1:0];
        if (scan_hit) begin
          state_next = lwps_pkg::ST_CRD;
        end else if (scan_last) begin
          state_next = lwps_pkg::ST_DONE;
          if (alloc_ok) begin
            // new link takes the lowest free slot with fresh counts
            link_we     = 1'b1;
            cnt_we      = 1'b1;
            cnt_wa      = alloc_idx;
            cnt_wd.win  = (cmd_q == lwps_pkg::CMD_WON) ? lwps_pkg::CNT_W'(1) : '0;
            cnt_wd.part = lwps_pkg::CNT_W'(1);
          end
        end
      end
      lwps_pkg::ST_CRD: begin
        rd_en      = 1'b1;
        rd_addr    = slot;
        state_next = lwps_pkg::ST_CWR;
      end
      lwps_pkg::ST_CWR: begin
        // saturating increment of the matched slot
        cnt_we      = 1'b1;
        cnt_wa      = slot;
        cnt_wd.win  = cnt_q.win;
        if ((cmd_q == lwps_pkg::CMD_WON) && (cnt_q.win != lwps_pkg::CNT_MAX)) begin
          cnt_wd.win = cnt_q.win + lwps_pkg::CNT_W'(1);
        end
        cnt_wd.part = (cnt_q.part != lwps_pkg::CNT_MAX) ?
                      cnt_q.part + lwps_pkg::CNT_W'(1) : cnt_q.part;
        state_next  = lwps_pkg::ST_DONE;
      end
      lwps_pkg::ST_TRD: begin
        rd_en      = 1'b1;
        rd_addr    = idx;
        state_next = lwps_pkg::ST_TMUL;
      end
      lwps_pkg::ST_TMUL: begin
        // products start; counts written back halved (pick sees old values)
        ratio_en    = 1'b1;
        cnt_we      = 1'b1;
        cnt_wa      = idx;
        cnt_wd.win  = cnt_q.win >> 1;
        cnt_wd.part = cnt_q.part >> 1;
        state_next  = lwps_pkg::ST_TCMP;
      end
      lwps_pkg::ST_TCMP: begin
        if (idx == LAST_IDX) begin
          state_next = lwps_pkg::ST_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = idx + IDX_W'(1);
          state_next = lwps_pkg::ST_TMUL;
        end
      end
      lwps_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (!rsp_valid || !rsp_stall) begin
          state_next = lwps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lwps_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath and control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      epoch     <= '0;
      rsp_valid <= 1'b0;
      rd_vld    <= 1'b0;
      free_ok   <= 1'b0;
      have      <= 1'b0;
      iss       <= '0;
    end else begin
      // a response taken while a new one is loaded keeps valid high
      if (rsp_valid && !rsp_stall && (state != lwps_pkg::ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        lwps_pkg::ST_IDLE: begin
          if (req_valid) begin
            cmd_q   <= req.command;
            id_q    <= req.link_id;
            iss     <= '0;
            rd_vld  <= 1'b0;
            free_ok <= 1'b0;
            idx     <= '0;
            have    <= 1'b0;
            res_q   <= '{best_link: '0, feedback_sent: 1'b0, epoch: epoch,
                         table_full: 1'b0};
            if (req.command == lwps_pkg::CMD_CLEAR) begin
              // counts of a free slot are rewritten on allocation
              used <= '0;
            end
          end
        end
        lwps_pkg::ST_SCAN: begin
          rd_vld <= iss_more;
          rd_idx <= iss[IDX_W-1:0];
          if (iss_more) begin
            iss <= iss + ISS_W'(1);
          end
          if (rd_vld && !scan_used && !free_ok) begin
            free_ok  <= 1'b1;
            free_idx <= rd_idx;
          end
          if (scan_hit) begin
            slot <= rd_idx;
          end else if (scan_last) begin
            if (alloc_ok) begin
              used[alloc_idx] <= 1'b1;
            end else begin
              res_q.table_full <= 1'b1;
            end
          end
        end
        lwps_pkg::ST_TMUL: begin
          cand_q  <= cand_in;
          cand_ok <= used[idx] && (cnt_q.part != '0);
        end
        lwps_pkg::ST_TCMP: begin
          if (take) begin
            best <= cand_q;
            have <= 1'b1;
          end
          if (idx == LAST_IDX) begin
            if (have || take) begin
              epoch               <= epoch + 32'd1;
              res_q.epoch         <= epoch + 32'd1;
              res_q.feedback_sent <= 1'b1;
              res_q.best_link     <= take ? cand_q.link : best.link;
            end
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        lwps_pkg::ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res_q;
            rsp_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/lwps_ratio_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwps_ratio_cmp
// exact win-ratio compare by registered cross products
// ----------------------------------------------------------------------------
module lwps_ratio_cmp (
  input  logic             clk,
  input  logic             en,
  input  lwps_pkg::ratio_t cand,
  input  lwps_pkg::ratio_t best,
  output logic             better
);

  logic [2*lwps_pkg::CNT_W-1:0]  lhs;
  logic [2*lwps_pkg::CNT_W-1:0]  rhs;
  logic [lwps_pkg::CNT_W-1:0]    cand_part;
  logic [lwps_pkg::CNT_W-1:0]    lead_part;
  logic [lwps_pkg::LINK_W-1:0]   cand_link;
  logic [lwps_pkg::LINK_W-1:0]   best_link;

  always_ff @(posedge clk) begin
    if (en) begin
      lhs       <= (2*lwps_pkg::CNT_W)'(cand.win) * (2*lwps_pkg::CNT_W)'(best.part);
      rhs       <= (2*lwps_pkg::CNT_W)'(best.win) * (2*lwps_pkg::CNT_W)'(cand.part);
      cand_part <= cand.part;
      lead_part <= best.part;
      cand_link <= cand.link;
      best_link <= best.link;
    end
  end

  // higher ratio, then larger participation, then lower id
  always_comb begin
    if (lhs != rhs) begin
      better = lhs > rhs;
    end else if (cand_part != lead_part) begin
      better = cand_part > lead_part;
    end else begin
      better = cand_link < best_link;
    end
  end

endmodule
